/* rtl/core/gbn_pkg.sv */
// Shared types, constants and microcode step addresses for the Go-Back-N link controller.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps
`default_nettype none

package gbn_pkg;

    localparam int SEQ_W     = 3;
    localparam int MAX_SEQ   = 7;
    localparam int HANDLE_W  = 16;
    localparam int LEN_W     = 10;
    localparam int BYTE_W    = 8;
    localparam int PC_W      = 5;
    localparam int S_TDATA_W = 56;
    localparam int M_TDATA_W = 40;

    localparam int DLEN_OFFSET   = 7;
    localparam int MIN_FRAME_LEN = 5;

    typedef logic [SEQ_W-1:0]    t_seq;
    typedef logic [HANDLE_W-1:0] t_handle;
    typedef logic [LEN_W-1:0]    t_len;
    typedef logic [BYTE_W-1:0]   t_byte;
    typedef logic [PC_W-1:0]     t_pc;

    localparam t_seq SEQ_MAX = t_seq'(MAX_SEQ);

    localparam t_byte KIND_DATA = 8'd1;
    localparam t_byte KIND_ACK  = 8'd2;
    localparam t_byte KIND_NAK  = 8'd3;

    typedef enum logic [2:0] {
        OPC_PKT_READY    = 3'd0,
        OPC_PHY_READY    = 3'd1,
        OPC_FRAME_RX     = 3'd2,
        OPC_ACK_TIMEOUT  = 3'd3,
        OPC_DATA_TIMEOUT = 3'd4
    } t_opcode;

    typedef enum logic [2:0] {
        ACT_SEND_DATA  = 3'd0,
        ACT_SEND_NAK   = 3'd1,
        ACT_SEND_ACK   = 3'd2,
        ACT_DELIVER    = 3'd3,
        ACT_STOP_TIMER = 3'd4,
        ACT_STATUS     = 3'd5
    } t_action;

    // Branch conditions the datapath reports to the sequencer
    typedef enum logic [2:0] {
        C_WIN_FULL,
        C_BAD_FRAME,
        C_NAK_OK,
        C_KIND_NAK,
        C_DELIVER,
        C_REL_DONE,
        C_RS_DONE
    } t_cond;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_STORE,
        OP_SEND,
        OP_PHY_SET,
        OP_NAK_TX,
        OP_DELIVER,
        OP_REL_INIT,
        OP_STOP,
        OP_NAK_INIT,
        OP_RS_NAK,
        OP_DTO_INIT,
        OP_ACK_TX
    } t_dp_op;

    typedef enum logic [1:0] {
        J_NEXT,
        J_GOTO,
        J_COND,
        J_DISPATCH
    } t_jump;

    typedef struct packed {
        logic    emit;
        t_action action;
        t_dp_op  op;
        t_cond   cond;
        logic    cond_inv;
        t_jump   jump;
        t_pc     target;
    } t_ucode;

    typedef struct packed {
        logic win_full;
        logic bad_frame;
        logic nak_ok;
        logic kind_nak;
        logic deliver_ok;
        logic rel_done;
        logic rs_done;
        logic out_free;
    } t_dp_flags;

    typedef struct packed {
        logic accept;
        logic fire;
    } t_seq_ctl;

    typedef struct packed {
        t_action action;
        t_seq    seq;
        t_seq    ack;
        t_handle handle;
        t_len    dlen;
        logic    en;
        logic    last;
    } t_result;

    // Microprogram step addresses
    localparam t_pc S_IDLE     = 5'd0;
    localparam t_pc S_DISPATCH = 5'd1;
    localparam t_pc S_PKT      = 5'd2;
    localparam t_pc S_PKT_STOR = 5'd3;
    localparam t_pc S_PKT_SEND = 5'd4;
    localparam t_pc S_PHY      = 5'd5;
    localparam t_pc S_FRM      = 5'd6;
    localparam t_pc S_FRM_BAD  = 5'd7;
    localparam t_pc S_NAK_TX   = 5'd8;
    localparam t_pc S_FRM_OK   = 5'd9;
    localparam t_pc S_DLV_CHK  = 5'd10;
    localparam t_pc S_DLV      = 5'd11;
    localparam t_pc S_ACK_INIT = 5'd12;
    localparam t_pc S_REL_A    = 5'd13;
    localparam t_pc S_STOP_A   = 5'd14;
    localparam t_pc S_NAK_RX   = 5'd15;
    localparam t_pc S_REL_N    = 5'd16;
    localparam t_pc S_STOP_N   = 5'd17;
    localparam t_pc S_RS_NAK   = 5'd18;
    localparam t_pc S_DTO      = 5'd19;
    localparam t_pc S_RS_LOOP  = 5'd20;
    localparam t_pc S_RESEND   = 5'd21;
    localparam t_pc S_ACK_TO   = 5'd22;
    localparam t_pc S_STATUS   = 5'd23;

endpackage

`default_nettype wire

/* rtl/core/go_back_n_link_controller_unit.sv */
// Top level of the Go-Back-N link controller: control store, sequencer and datapath.
// Depends on gbn_pkg, gbn_ucode_rom, gbn_sequencer and gbn_datapath.
`timescale 1ns / 1ps
`default_nettype none

// Go-Back-N ARQ link controller with 3-bit sequence numbers. Each request on the slave
// stream is one link event (tuser = opcode); the master stream returns the commands it
// causes, one per beat, ending with a status item flagged by tlast. Control runs as a
// microprogram of one step per cycle, holding while an emitting step finds the command
// register taken, and a request is taken only when the previous program has finished.
// A NAK, or an in-order data frame, can cause up to seven timer stops or resends; each
// costs a window test and the command itself on top of the decision steps. One command
// register decouples the output; the next request is taken while the final status item
// still waits.
module go_back_n_link_controller_unit
    import gbn_pkg::*;
(
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_s_tvalid,
    output logic                 o_s_tready,
    // crc_good[0], frame_length[10:1], frame_kind[18:11], frame_seq[26:19],
    // rx_ack[34:27], packet_handle[50:35], zeros above
    input  wire [S_TDATA_W-1:0]  i_s_tdata,
    // opcode[2:0]
    input  wire [2:0]            i_s_tuser,
    output logic                 o_m_tvalid,
    input  wire                  i_m_tready,
    // seq_number[2:0], ack_number[5:3], handle_out[21:6], deliver_length[31:22],
    // network_enable[32], zeros above
    output logic [M_TDATA_W-1:0] o_m_tdata,
    // action[2:0]
    output logic [2:0]           o_m_tuser,
    output logic                 o_m_tlast
);

    t_pc       pc;
    t_ucode    cw;
    t_dp_flags flags;
    t_seq_ctl  ctl;

    gbn_ucode_rom u_rom (
        .i_pc (pc),
        .o_cw (cw)
    );

    gbn_sequencer u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_tvalid),
        .i_opcode   (t_opcode'(i_s_tuser)),
        .i_cw       (cw),
        .i_flags    (flags),
        .o_pc       (pc),
        .o_ready    (o_s_tready),
        .o_ctl      (ctl)
    );

    gbn_datapath u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (ctl),
        .i_cw       (cw),
        .i_s_tdata  (i_s_tdata),
        .i_m_tready (i_m_tready),
        .o_flags    (flags),
        .o_m_tvalid (o_m_tvalid),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .o_m_tlast  (o_m_tlast)
    );

`ifndef SYNTHESIS
    // a taken request starts the program, so no second request on the next edge
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> !o_s_tready)
        else $error("request taken while program still running");

    // a command other than status means its event has not finished
    a_mid_cmd_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !o_m_tlast) |-> !o_s_tready)
        else $error("sequencer idle with a non-final command pending");

    // only the status item closes an event
    a_last_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tlast) |-> (o_m_tuser == ACT_STATUS))
        else $error("tlast on a command that is not status");
`endif

endmodule

`default_nettype wire

/* rtl/core/gbn_ucode_rom.sv */
// Control store: one microcode word per step of the link controller program.
// Depends on gbn_pkg for the word layout and step addresses.
`timescale 1ns / 1ps
`default_nettype none

module gbn_ucode_rom
    import gbn_pkg::*;
(
    input  wire t_pc    i_pc,
    output t_ucode      o_cw
);

    function automatic t_ucode mk(input logic emit, input t_action action, input t_dp_op op,
                                  input t_cond cond, input logic inv, input t_jump jump,
                                  input t_pc target);
        t_ucode w;
        w.emit     = emit;
        w.action   = action;
        w.op       = op;
        w.cond     = cond;
        w.cond_inv = inv;
        w.jump     = jump;
        w.target   = target;
        return w;
    endfunction

    always_comb begin
        unique case (i_pc)
            S_IDLE:     o_cw = mk(1'b0, ACT_STATUS, OP_NONE, C_WIN_FULL, 1'b0, J_NEXT, S_IDLE);
            S_DISPATCH: o_cw = mk(1'b0, ACT_STATUS, OP_NONE, C_WIN_FULL, 1'b0, J_DISPATCH,
                                  S_STATUS);
            // packet ready: drop when the window is full
            S_PKT:      o_cw = mk(1'b0, ACT_STATUS, OP_NONE, C_WIN_FULL, 1'b0, J_COND, S_STATUS);
            S_PKT_STOR: o_cw = mk(1'b0, ACT_STATUS, OP_STORE, C_WIN_FULL, 1'b0, J_NEXT, S_IDLE);
            S_PKT_SEND: o_cw = mk(1'b1, ACT_SEND_DATA, OP_SEND, C_WIN_FULL, 1'b0, J_GOTO,
                                  S_STATUS);
            S_PHY:      o_cw = mk(1'b0, ACT_STATUS, OP_PHY_SET, C_WIN_FULL, 1'b0, J_GOTO,
                                  S_STATUS);
            // frame received
            S_FRM:      o_cw = mk(1'b0, ACT_STATUS, OP_NONE, C_BAD_FRAME, 1'b1, J_COND, S_FRM_OK);
            S_FRM_BAD:  o_cw = mk(1'b0, ACT_STATUS, OP_NONE, C_NAK_OK, 1'b1, J_COND, S_STATUS);
            S_NAK_TX:   o_cw = mk(1'b1, ACT_SEND_NAK, OP_NAK_TX, C_WIN_FULL, 1'b0, J_GOTO,
                                  S_STATUS);
            S_FRM_OK:   o_cw = mk(1'b0, ACT_STATUS, OP_NONE, C_KIND_NAK, 1'b0, J_COND, S_NAK_RX);
            S_DLV_CHK:  o_cw = mk(1'b0, ACT_STATUS, OP_NONE, C_DELIVER, 1'b1, J_COND,
                                  S_ACK_INIT);
            S_DLV:      o_cw = mk(1'b1, ACT_DELIVER, OP_DELIVER, C_WIN_FULL, 1'b0, J_NEXT,
                                  S_IDLE);
            S_ACK_INIT: o_cw = mk(1'b0, ACT_STATUS, OP_REL_INIT, C_WIN_FULL, 1'b0, J_NEXT,
                                  S_IDLE);
            S_REL_A:    o_cw = mk(1'b0, ACT_STATUS, OP_NONE, C_REL_DONE, 1'b0, J_COND, S_STATUS);
            S_STOP_A:   o_cw = mk(1'b1, ACT_STOP_TIMER, OP_STOP, C_WIN_FULL, 1'b0, J_GOTO,
                                  S_REL_A);
            // NAK received: rewind, release what it acknowledges, resend the rest
            S_NAK_RX:   o_cw = mk(1'b0, ACT_STATUS, OP_NAK_INIT, C_WIN_FULL, 1'b0, J_NEXT,
                                  S_IDLE);
            S_REL_N:    o_cw = mk(1'b0, ACT_STATUS, OP_NONE, C_REL_DONE, 1'b0, J_COND, S_RS_NAK);
            S_STOP_N:   o_cw = mk(1'b1, ACT_STOP_TIMER, OP_STOP, C_WIN_FULL, 1'b0, J_GOTO,
                                  S_REL_N);
            S_RS_NAK:   o_cw = mk(1'b0, ACT_STATUS, OP_RS_NAK, C_WIN_FULL, 1'b0, J_GOTO,
                                  S_RS_LOOP);
            S_DTO:      o_cw = mk(1'b0, ACT_STATUS, OP_DTO_INIT, C_WIN_FULL, 1'b0, J_NEXT,
                                  S_IDLE);
            S_RS_LOOP:  o_cw = mk(1'b0, ACT_STATUS, OP_NONE, C_RS_DONE, 1'b0, J_COND, S_STATUS);
            S_RESEND:   o_cw = mk(1'b1, ACT_SEND_DATA, OP_SEND, C_WIN_FULL, 1'b0, J_GOTO,
                                  S_RS_LOOP);
            S_ACK_TO:   o_cw = mk(1'b1, ACT_SEND_ACK, OP_ACK_TX, C_WIN_FULL, 1'b0, J_GOTO,
                                  S_STATUS);
            S_STATUS:   o_cw = mk(1'b1, ACT_STATUS, OP_NONE, C_WIN_FULL, 1'b0, J_GOTO, S_IDLE);
            default:    o_cw = mk(1'b0, ACT_STATUS, OP_NONE, C_WIN_FULL, 1'b0, J_GOTO, S_IDLE);
        endcase
    end

endmodule

`default_nettype wire

/* rtl/core/gbn_sequencer.sv */
// Step counter of the microprogram: event dispatch, conditional jumps and stall on output.
// Depends on gbn_pkg; reads words from gbn_ucode_rom and flags from gbn_datapath.
`timescale 1ns / 1ps
`default_nettype none

module gbn_sequencer
    import gbn_pkg::*;
(
    input  wire             i_clk,
    input  wire             i_rst_n,
    input  wire             i_in_valid,
    input  wire t_opcode    i_opcode,
    input  wire t_ucode     i_cw,
    input  wire t_dp_flags  i_flags,
    output t_pc             o_pc,
    output logic            o_ready,
    output t_seq_ctl        o_ctl
);

    t_pc     r_pc;
    t_pc     n_pc;
    t_opcode r_opcode;
    logic    cond_hit;
    logic    cond_raw;
    t_pc     dispatch_pc;

    assign o_pc    = r_pc;
    assign o_ready = (r_pc == S_IDLE);

    always_comb begin
        o_ctl.accept = o_ready && i_in_valid;
        // hold the step while an emitting word finds the output register taken
        o_ctl.fire   = !o_ready && (!i_cw.emit || i_flags.out_free);
    end

    always_comb begin
        unique case (i_cw.cond)
            C_WIN_FULL:  cond_raw = i_flags.win_full;
            C_BAD_FRAME: cond_raw = i_flags.bad_frame;
            C_NAK_OK:    cond_raw = i_flags.nak_ok;
            C_KIND_NAK:  cond_raw = i_flags.kind_nak;
            C_DELIVER:   cond_raw = i_flags.deliver_ok;
            C_REL_DONE:  cond_raw = i_flags.rel_done;
            C_RS_DONE:   cond_raw = i_flags.rs_done;
            default:     cond_raw = 1'b0;
        endcase
        cond_hit = cond_raw ^ i_cw.cond_inv;
    end

    always_comb begin
        unique case (r_opcode)
            OPC_PKT_READY:    dispatch_pc = S_PKT;
            OPC_PHY_READY:    dispatch_pc = S_PHY;
            OPC_FRAME_RX:     dispatch_pc = S_FRM;
            OPC_ACK_TIMEOUT:  dispatch_pc = S_ACK_TO;
            OPC_DATA_TIMEOUT: dispatch_pc = S_DTO;
            default:          dispatch_pc = S_STATUS;
        endcase
    end

    always_comb begin
        n_pc = r_pc;
        if (o_ready) begin
            if (i_in_valid) begin
                n_pc = S_DISPATCH;
            end
        end else if (o_ctl.fire) begin
            unique case (i_cw.jump)
                J_NEXT:     n_pc = r_pc + t_pc'(1);
                J_GOTO:     n_pc = i_cw.target;
                J_COND:     n_pc = cond_hit ? i_cw.target : r_pc + t_pc'(1);
                J_DISPATCH: n_pc = dispatch_pc;
                default:    n_pc = S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= S_IDLE;
        end else begin
            r_pc <= n_pc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ctl.accept) begin
            r_opcode <= i_opcode;
        end
    end

endmodule

`default_nettype wire

/* rtl/core/gbn_datapath.sv */
// Window registers, handle store, branch flags and the result register of the controller.
// Depends on gbn_pkg; driven by the control word and the sequencer's fire strobe.
`timescale 1ns / 1ps
`default_nettype none

module gbn_datapath
    import gbn_pkg::*;
(
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire t_seq_ctl        i_ctl,
    input  wire t_ucode          i_cw,
    input  wire [S_TDATA_W-1:0]  i_s_tdata,
    input  wire                  i_m_tready,
    output t_dp_flags            o_flags,
    output logic                 o_m_tvalid,
    output logic [M_TDATA_W-1:0] o_m_tdata,
    output logic [2:0]           o_m_tuser,
    output logic                 o_m_tlast
);

    // window and link state
    t_seq r_next;
    t_seq r_oldest;
    t_seq r_count;
    t_seq r_expected;
    logic r_nak_ok;
    logic r_phy;
    t_seq r_ack_target;
    t_seq r_rel_n;
    t_seq r_rs_cnt;

    // request fields held for the whole program run
    logic    r_crc;
    t_len    r_len;
    t_byte   r_kind;
    t_byte   r_fseq;
    t_seq    r_fack;
    t_handle r_handle;

    t_handle r_store [MAX_SEQ+1];

    logic    r_out_valid;
    t_result r_out;
    t_result res;
    t_seq    rs_limit;
    t_seq    rs_nak_cnt;
    logic    emit_now;

    function automatic logic in_window(input t_seq a, input t_seq b, input t_seq c);
        return ((a <= b) && (b < c)) || ((c < a) && (a <= b)) || ((b < c) && (c < a));
    endfunction

    assign emit_now = i_ctl.fire && i_cw.emit;

    always_comb begin
        o_flags.win_full   = (r_count == SEQ_MAX);
        o_flags.bad_frame  = (r_len < t_len'(MIN_FRAME_LEN)) || !r_crc;
        o_flags.nak_ok     = r_nak_ok && (r_fseq == {{(BYTE_W-SEQ_W){1'b0}}, r_expected});
        o_flags.kind_nak   = (r_kind == KIND_NAK);
        o_flags.deliver_ok = (r_kind == KIND_DATA)
                             && (r_fseq == {{(BYTE_W-SEQ_W){1'b0}}, r_expected});
        o_flags.rel_done   = (r_rel_n == SEQ_MAX) || !in_window(r_oldest, r_ack_target, r_next);
        o_flags.rs_done    = (r_rs_cnt == '0);
        o_flags.out_free   = !r_out_valid || i_m_tready;
    end

    // resend budget after a NAK: stops already sent eat into it
    always_comb begin
        rs_limit   = SEQ_MAX - r_rel_n;
        rs_nak_cnt = (r_count < rs_limit) ? r_count : rs_limit;
    end

    always_comb begin
        res        = '0;
        res.action = i_cw.action;
        unique case (i_cw.action)
            ACT_SEND_DATA: begin
                res.seq    = r_next;
                res.ack    = r_expected - t_seq'(1);
                res.handle = r_store[r_next];
            end
            ACT_SEND_NAK: begin
                res.ack = r_expected;
            end
            ACT_SEND_ACK: begin
                res.ack = r_expected - t_seq'(1);
            end
            ACT_DELIVER: begin
                res.dlen = (r_len >= t_len'(DLEN_OFFSET)) ? r_len - t_len'(DLEN_OFFSET) : '0;
            end
            ACT_STOP_TIMER: begin
                res.seq = r_oldest;
            end
            ACT_STATUS: begin
                res.en   = (r_count != SEQ_MAX) && r_phy;
                res.last = 1'b1;
            end
            default: begin
                res = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_next       <= '0;
            r_oldest     <= '0;
            r_count      <= '0;
            r_expected   <= '0;
            r_nak_ok     <= 1'b1;
            r_phy        <= 1'b0;
            r_ack_target <= '0;
            r_rel_n      <= '0;
            r_rs_cnt     <= '0;
        end else if (i_ctl.fire) begin
            unique case (i_cw.op)
                OP_NONE: begin
                end
                OP_STORE: begin
                    r_count <= r_count + t_seq'(1);
                end
                OP_SEND: begin
                    r_phy    <= 1'b0;
                    r_next   <= r_next + t_seq'(1);
                    r_rs_cnt <= r_rs_cnt - t_seq'(1);
                end
                OP_PHY_SET: begin
                    r_phy <= 1'b1;
                end
                OP_NAK_TX: begin
                    r_phy    <= 1'b0;
                    r_nak_ok <= 1'b0;
                end
                OP_DELIVER: begin
                    r_nak_ok   <= 1'b1;
                    r_expected <= r_expected + t_seq'(1);
                end
                OP_REL_INIT: begin
                    r_ack_target <= r_fack;
                    r_rel_n      <= '0;
                end
                OP_STOP: begin
                    if (r_count != '0) begin
                        r_count <= r_count - t_seq'(1);
                    end
                    r_oldest <= r_oldest + t_seq'(1);
                    r_rel_n  <= r_rel_n + t_seq'(1);
                end
                OP_NAK_INIT: begin
                    r_next       <= r_fack;
                    r_ack_target <= r_fack - t_seq'(1);
                    r_rel_n      <= '0;
                end
                OP_RS_NAK: begin
                    r_rs_cnt <= rs_nak_cnt;
                end
                OP_DTO_INIT: begin
                    r_next   <= r_oldest;
                    r_rs_cnt <= (r_count < SEQ_MAX) ? r_count : SEQ_MAX;
                end
                OP_ACK_TX: begin
                    r_phy <= 1'b0;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.fire && (i_cw.op == OP_STORE)) begin
            r_store[r_next] <= r_handle;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.accept) begin
            r_crc    <= i_s_tdata[0];
            r_len    <= i_s_tdata[10:1];
            r_kind   <= i_s_tdata[18:11];
            r_fseq   <= i_s_tdata[26:19];
            r_fack   <= i_s_tdata[29:27];
            r_handle <= i_s_tdata[50:35];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit_now) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit_now) begin
            r_out <= res;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {7'b0, r_out.en, r_out.dlen, r_out.handle, r_out.ack, r_out.seq};
    assign o_m_tuser  = r_out.action;
    assign o_m_tlast  = r_out.last;

endmodule

`default_nettype wire

/* bench/tb_go_back_n_link_controller_unit.sv */
// Self-checking bench for the Go-Back-N link controller: directed and random link events
// on the slave stream, predicted commands compared against the master stream.
// Depends on gbn_pkg and go_back_n_link_controller_unit.
`timescale 1ns / 1ps

module tb_go_back_n_link_controller_unit;
    import gbn_pkg::*;

    localparam int        CLK_HALF      = 4;
    localparam int        EVENT_TARGET  = 330;
    localparam int        NOISE_PCT     = 25;
    localparam int        IDLE_HEAVY    = 63;
    localparam int        IDLE_LIGHT    = 20;
    localparam int        TAIL_CYCLES   = 40;
    localparam logic [2:0] OPC_SPARE_LO = 3'd5;
    localparam logic [2:0] OPC_SPARE_HI = 3'd7;

    typedef struct packed {
        logic [2:0] opcode;
        logic       crc_good;
        t_len       len;
        t_byte      kind;
        t_byte      seq;
        t_byte      ack;
        t_handle    handle;
    } link_event_t;

    // Sender and receiver windows plus the handle kept for each outstanding sequence
    typedef struct packed {
        logic [MAX_SEQ:0][HANDLE_W-1:0] handles;
        logic [MAX_SEQ:0]               written;
        t_seq                           nts;
        t_seq                           oldest;
        t_seq                           count;
        t_seq                           expseq;
        logic                           nak_ok;
        logic                           phy;
    } link_state_t;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_s_tvalid = 1'b0;
    logic                  o_s_tready;
    logic [S_TDATA_W-1:0]  i_s_tdata = '0;
    logic [2:0]            i_s_tuser = '0;
    logic                  o_m_tvalid;
    logic                  i_m_tready = 1'b0;
    logic [M_TDATA_W-1:0]  o_m_tdata;
    logic [2:0]            o_m_tuser;
    logic                  o_m_tlast;

    link_state_t  link;
    logic         stale_read;
    t_result      step_cmds[$];
    t_result      planned_cmds[$];
    int           cmds_per_event[$];
    link_event_t  pending_events[$];
    bit           drain_marks[$];
    t_result      expected_cmds[$];

    int n_events = 1;
    int busy_events = 0;
    int taken_cnt = 0;
    int pending_results = 0;
    int errors = 0;
    int act_seen[ACT_STATUS+1];

    go_back_n_link_controller_unit u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .o_m_tlast  (o_m_tlast)
    );

    always #(CLK_HALF) i_clk = ~i_clk;

    function automatic void emit_cmd(t_action act, t_seq sq, t_seq ak, t_handle hd, t_len dl,
                                     logic en, logic lst);
        t_result r;
        r.action = act;
        r.seq    = sq;
        r.ack    = ak;
        r.handle = hd;
        r.dlen   = dl;
        r.en     = en;
        r.last   = lst;
        step_cmds.push_back(r);
    endfunction

    function automatic bit between(t_seq a, t_seq b, t_seq c);
        return (a <= b && b < c) || (c < a && a <= b) || (b < c && c < a);
    endfunction

    function automatic void tx_data_pkt();
        t_seq s;
        s = link.nts;
        if (!link.written[s])
            stale_read = 1'b1;
        emit_cmd(ACT_SEND_DATA, s, link.expseq + SEQ_MAX, link.handles[s], '0, 1'b0, 1'b0);
        link.phy = 1'b0;
        link.nts = s + 1'b1;
    endfunction

    // Stop timers from the oldest unacked frame up to and including ack
    function automatic int release_upto(t_seq ak);
        int n;
        n = 0;
        while (n < MAX_SEQ && between(link.oldest, ak, link.nts)) begin
            emit_cmd(ACT_STOP_TIMER, link.oldest, '0, '0, '0, 1'b0, 1'b0);
            if (link.count != 0)
                link.count = link.count - 1'b1;
            link.oldest = link.oldest + 1'b1;
            n++;
        end
        return n;
    endfunction

    function automatic void resend_window(int limit);
        int n;
        n = (link.count < limit) ? link.count : limit;
        for (int i = 0; i < n; i++)
            tx_data_pkt();
    endfunction

    function automatic void predict_event(link_event_t ev);
        t_seq fack;
        int   stops;
        fack = ev.ack[SEQ_W-1:0];
        case (ev.opcode)
            OPC_PKT_READY: begin
                if (link.count < SEQ_MAX) begin
                    link.count = link.count + 1'b1;
                    link.handles[link.nts] = ev.handle;
                    link.written[link.nts] = 1'b1;
                    tx_data_pkt();
                end
            end
            OPC_PHY_READY: begin
                link.phy = 1'b1;
            end
            OPC_FRAME_RX: begin
                if (ev.len < MIN_FRAME_LEN || !ev.crc_good) begin
                    // one NAK per expected frame until it arrives
                    if (link.nak_ok && ev.seq == link.expseq) begin
                        emit_cmd(ACT_SEND_NAK, '0, link.expseq, '0, '0, 1'b0, 1'b0);
                        link.phy = 1'b0;
                        link.nak_ok = 1'b0;
                    end
                end else if (ev.kind == KIND_NAK) begin
                    link.nts = fack;
                    stops = release_upto(fack + SEQ_MAX);
                    resend_window(MAX_SEQ - stops);
                end else begin
                    if (ev.kind == KIND_DATA && ev.seq == link.expseq) begin
                        emit_cmd(ACT_DELIVER, '0, '0, '0,
                                 (ev.len >= DLEN_OFFSET) ? t_len'(ev.len - DLEN_OFFSET) : '0,
                                 1'b0, 1'b0);
                        link.nak_ok = 1'b1;
                        link.expseq = link.expseq + 1'b1;
                    end
                    stops = release_upto(fack);
                end
            end
            OPC_ACK_TIMEOUT: begin
                emit_cmd(ACT_SEND_ACK, '0, link.expseq + SEQ_MAX, '0, '0, 1'b0, 1'b0);
                link.phy = 1'b0;
            end
            OPC_DATA_TIMEOUT: begin
                link.nts = link.oldest;
                resend_window(MAX_SEQ);
            end
            default: begin
            end
        endcase
        emit_cmd(ACT_STATUS, '0, '0, '0, '0, (link.count < SEQ_MAX) && link.phy, 1'b1);
    endfunction

    // Queue one event with its commands; drop it if it would resend a never-written slot
    function automatic void add_event(logic [2:0] op, logic crc, t_len len, t_byte kind,
                                      t_byte sq, t_byte ak, t_handle hd);
        link_event_t ev;
        link_state_t saved;
        ev.opcode   = op;
        ev.crc_good = crc;
        ev.len      = len;
        ev.kind     = kind;
        ev.seq      = sq;
        ev.ack      = ak;
        ev.handle   = hd;
        saved = link;
        step_cmds.delete();
        stale_read = 1'b0;
        predict_event(ev);
        if (stale_read) begin
            link = saved;
        end else begin
            pending_events.push_back(ev);
            drain_marks.push_back(1'b0);
            cmds_per_event.push_back(step_cmds.size());
            foreach (step_cmds[i])
                planned_cmds.push_back(step_cmds[i]);
            if (step_cmds.size() > 1 || op == OPC_PHY_READY)
                busy_events++;
        end
    endfunction

    function automatic void random_event();
        int         pick;
        logic [2:0] op;
        logic       crc;
        t_len       len;
        t_byte      kind;
        t_byte      sq;
        t_byte      ak;
        t_handle    hd;
        t_seq       s3;
        pick = $urandom_range(99, 0);
        op   = 3'($urandom_range(OPC_SPARE_HI, 0));
        crc  = 1'($urandom);
        len  = t_len'($urandom);
        kind = t_byte'($urandom);
        sq   = t_byte'($urandom);
        ak   = t_byte'($urandom);
        hd   = t_handle'($urandom);
        if (pick >= NOISE_PCT) begin
            // aim acks into the send window and data at the expected sequence
            s3 = link.oldest + t_seq'($urandom_range(link.count, 0));
            if ($urandom_range(9, 0) != 0)
                ak = '0;
            ak[SEQ_W-1:0] = s3;
            if ($urandom_range(4, 0) != 0)
                sq = link.expseq;
            crc = 1'b1;
            len = ($urandom_range(9, 0) == 0)
                  ? t_len'($urandom_range(DLEN_OFFSET - 1, MIN_FRAME_LEN))
                  : t_len'($urandom_range(1023, DLEN_OFFSET));
            pick = $urandom_range(99, 0);
            if (pick < 30) begin
                op = OPC_PKT_READY;
            end else if (pick < 45) begin
                op = OPC_PHY_READY;
            end else if (pick < 75) begin
                op = OPC_FRAME_RX;
                pick = $urandom_range(9, 0);
                if (pick < 6)
                    kind = KIND_DATA;
                else if (pick < 8)
                    kind = KIND_ACK;
                else if (pick == 8)
                    kind = KIND_NAK;
            end else if (pick < 83) begin
                op = OPC_FRAME_RX;
                if ($urandom_range(1, 0))
                    crc = 1'b0;
                else
                    len = t_len'($urandom_range(MIN_FRAME_LEN - 1, 0));
            end else if (pick < 91) begin
                op = OPC_ACK_TIMEOUT;
            end else begin
                op = OPC_DATA_TIMEOUT;
            end
        end
        add_event(op, crc, len, kind, sq, ak, hd);
    endfunction

    function automatic int idle_pct(bit rx_side);
        int ph;
        ph = (taken_cnt * 5) / n_events;
        case (ph)
            1: return rx_side ? 0 : IDLE_HEAVY;
            2: return rx_side ? IDLE_HEAVY : 0;
            3: return IDLE_LIGHT;
            default: return 0;
        endcase
    endfunction

    function automatic void check_field(string name, int want, int got);
        if (want != got) begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            errors++;
        end
    endfunction

    // Request driver
    always @(posedge i_clk) begin : drv
        bit took;
        bit hold_off;
        took = i_s_tvalid && o_s_tready;
        if (!i_rst_n) begin
            i_s_tvalid <= 1'b0;
        end else begin
            if (took) begin
                void'(pending_events.pop_front());
                void'(drain_marks.pop_front());
                taken_cnt <= taken_cnt + 1;
            end
            if (!(i_s_tvalid && !took)) begin
                hold_off = pending_events.size() == 0 ||
                           (drain_marks[0] && (took || pending_results != 0)) ||
                           $urandom_range(99, 0) < idle_pct(1'b0);
                if (hold_off) begin
                    i_s_tvalid <= 1'b0;
                end else begin
                    i_s_tvalid <= 1'b1;
                    i_s_tuser  <= pending_events[0].opcode;
                    i_s_tdata  <= {{(S_TDATA_W - 51){1'b0}}, pending_events[0].handle,
                                   pending_events[0].ack, pending_events[0].seq,
                                   pending_events[0].kind, pending_events[0].len,
                                   pending_events[0].crc_good};
                end
            end
        end
    end

    // Command monitor and receiver stalls
    always @(posedge i_clk) begin : mon
        int      added;
        bit      took_out;
        t_result got;
        t_result want;
        added = 0;
        took_out = o_m_tvalid && i_m_tready && i_rst_n;
        if (i_rst_n && i_s_tvalid && o_s_tready) begin
            added = cmds_per_event.pop_front();
            repeat (added)
                expected_cmds.push_back(planned_cmds.pop_front());
        end
        if (took_out) begin
            got = {o_m_tuser, o_m_tdata[2:0], o_m_tdata[5:3], o_m_tdata[21:6],
                   o_m_tdata[31:22], o_m_tdata[32], o_m_tlast};
            if (expected_cmds.size() == 0) begin
                $error("unexpected command: action %0d tdata %h last %0b",
                       o_m_tuser, o_m_tdata, o_m_tlast);
                errors++;
            end else begin
                want = expected_cmds.pop_front();
                check_field("action", want.action, got.action);
                check_field("seq_number", want.seq, got.seq);
                check_field("ack_number", want.ack, got.ack);
                check_field("handle_out", want.handle, got.handle);
                check_field("deliver_length", want.dlen, got.dlen);
                check_field("network_enable", want.en, got.en);
                check_field("last", want.last, got.last);
                if (want.action <= ACT_STATUS)
                    act_seen[want.action]++;
            end
        end
        pending_results <= pending_results + added - (took_out ? 1 : 0);
        i_m_tready <= ($urandom_range(99, 0) >= idle_pct(1'b1));
    end

    initial begin : stim
        int checked;
        link = '0;
        link.nak_ok = 1'b1;

        add_event(OPC_SPARE_HI, 1'b1, '1, '1, '1, '1, '1);
        add_event(OPC_SPARE_LO, 1'b0, '0, '0, '0, '0, '0);
        add_event(OPC_PHY_READY, 1'b0, '0, '0, '0, '0, '0);
        add_event(OPC_PKT_READY, 1'b1, '1, '1, '1, '1, 16'hFFFF);
        add_event(OPC_PKT_READY, 1'b0, '0, '0, '0, '0, 16'h0000);
        add_event(OPC_PHY_READY, 1'b1, '1, '1, '1, '1, '1);
        add_event(OPC_ACK_TIMEOUT, 1'b0, '0, '0, '0, '0, '0);
        // bad CRC at the expected sequence: NAK once, then silence
        add_event(OPC_FRAME_RX, 1'b0, 10'd100, KIND_DATA, 8'd0, 8'd0, '0);
        add_event(OPC_FRAME_RX, 1'b0, 10'd100, KIND_DATA, 8'd0, 8'd0, '0);
        add_event(OPC_FRAME_RX, 1'b1, t_len'(MIN_FRAME_LEN - 1), KIND_DATA, 8'd0, 8'd0, '0);
        // short deliveries and the longest frame, ack byte above the sequence range
        add_event(OPC_FRAME_RX, 1'b1, t_len'(MIN_FRAME_LEN), KIND_DATA, 8'd0, 8'd0, '0);
        add_event(OPC_FRAME_RX, 1'b1, 10'd1023, KIND_DATA, 8'd1, 8'hFF, '0);
        add_event(OPC_FRAME_RX, 1'b1, t_len'(DLEN_OFFSET - 1), KIND_DATA, 8'd2, 8'hF8, '0);
        add_event(OPC_DATA_TIMEOUT, 1'b0, '0, '0, '0, '0, '0);
        // fill the window, then one more that must be dropped
        repeat (MAX_SEQ)
            add_event(OPC_PKT_READY, 1'b1, '0, '0, '0, '0, t_handle'($urandom));
        add_event(OPC_FRAME_RX, 1'b1, 10'd64, KIND_NAK, '0, t_byte'(link.oldest + 3'd3), '0);
        add_event(OPC_FRAME_RX, 1'b1, 10'd64, 8'hFF, '1, t_byte'(link.nts + SEQ_MAX), '0);
        add_event(OPC_DATA_TIMEOUT, 1'b1, '1, '1, '1, '1, '1);
        // sequence byte matches only in its low bits: no NAK
        add_event(OPC_FRAME_RX, 1'b0, 10'd20, KIND_DATA, t_byte'(link.expseq) | 8'h80, '0, '0);

        while (pending_events.size() < EVENT_TARGET)
            random_event();
        n_events = pending_events.size();
        drain_marks[(n_events * 2) / 5] = 1'b1;
        drain_marks[(n_events * 4) / 5] = 1'b1;

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        while (taken_cnt != n_events || pending_results != 0)
            @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (expected_cmds.size() != 0) begin
            $error("%0d commands never arrived", expected_cmds.size());
            errors++;
        end
        checked = 0;
        foreach (act_seen[i])
            checked += act_seen[i];
        $display("covered %0d link events (%0d with effect), %0d commands checked:",
                 n_events, busy_events, checked);
        $display("  data %0d, nak %0d, ack %0d, deliver %0d, timer stop %0d, status %0d",
                 act_seen[ACT_SEND_DATA], act_seen[ACT_SEND_NAK], act_seen[ACT_SEND_ACK],
                 act_seen[ACT_DELIVER], act_seen[ACT_STOP_TIMER], act_seen[ACT_STATUS]);
        if (errors == 0)
            $display("PASS go_back_n_link_controller_unit");
        else
            $display("FAIL go_back_n_link_controller_unit");
        $finish;
    end

    initial begin : watchdog
        #4_000_000;
        $error("timeout: %0d of %0d requests taken, %0d commands pending",
               taken_cnt, n_events, pending_results);
        $display("FAIL go_back_n_link_controller_unit");
        $finish;
    end

endmodule
